FILE: rtl/core/itra_pkg.sv
// shared constants, types and helpers for the radix integer-to-ascii converter
package itra_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_CHARS   = 64;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 8;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int STEP_BITS   = 8;
    localparam int DIV_STEPS   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W       = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0]  CHAR_NONE  = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DIGIT,
        ST_CHECK,
        ST_ERROR,
        ST_SIGN,
        ST_DOUT
    } state_t;

    typedef enum logic [1:0] {
        OUT_ERROR,
        OUT_SIGN,
        OUT_DIGIT
    } out_sel_t;

    typedef struct packed {
        logic load;
        logic step;
        logic digit_wr;
        logic fetch;
        logic err_sel;
        logic sign_sel;
    } itra_cmd_t;

    typedef struct packed {
        logic radix_ok;
        logic step_last;
        logic quot_zero;
        logic count_full;
        logic too_long;
        logic neg;
        logic idx_zero;
    } itra_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DIGIT_TEN) begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end else begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/itra_ram.sv
// generic single-port-write, registered-read ram
module itra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/itra_datapath.sv
// datapath: digit divider, digit store, counters and output character select
module itra_datapath
    import itra_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  itra_cmd_t            cmd,
    output itra_status_t         status,
    input  logic [63:0]          s_value,
    input  logic [RADIX_W-1:0]   s_radix,
    input  logic                 s_negative,
    output logic [CHAR_W-1:0]    m_character,
    output logic                 m_last,
    output logic                 m_error
);

    logic [PAD_W-1:0]      quot_reg;
    logic [RADIX_W-1:0]    rem_reg;
    logic [RADIX_W-1:0]    radix_reg;
    logic                  neg_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [STEP_CNT_W-1:0] step_cnt_reg;
    out_sel_t              out_sel_reg;

    logic [VALUE_WIDTH-1:0] in_masked;
    logic [VALUE_WIDTH-1:0] in_value;
    logic [PAD_W-1:0]       div_q;
    logic [RADIX_W-1:0]     div_r;
    logic [RADIX_W:0]       div_part;
    logic [COUNT_W-1:0]     count_dec;
    logic [RADIX_W-1:0]     ram_rdata;

    assign in_masked = s_value[VALUE_WIDTH-1:0];
    assign in_value  = s_negative ? (~in_masked + VALUE_WIDTH'(1)) : in_masked;
    assign count_dec = count_reg - COUNT_W'(1);

    // restoring division, STEP_BITS quotient bits per cycle
    always_comb begin
        div_q    = quot_reg;
        div_r    = rem_reg;
        div_part = '0;
        for (int j = 0; j < STEP_BITS; j++) begin
            div_part = {div_r, div_q[PAD_W-1]};
            div_q    = {div_q[PAD_W-2:0], 1'b0};
            if (div_part >= {1'b0, radix_reg}) begin
                div_part = div_part - {1'b0, radix_reg};
                div_q[0] = 1'b1;
            end
            div_r = div_part[RADIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            step_cnt_reg <= '0;
            out_sel_reg  <= OUT_ERROR;
        end else begin
            if (cmd.load) begin
                radix_reg    <= s_radix;
                neg_reg      <= s_negative;
                quot_reg     <= PAD_W'(in_value);
                rem_reg      <= '0;
                step_cnt_reg <= '0;
                count_reg    <= '0;
            end
            if (cmd.step) begin
                quot_reg     <= div_q;
                rem_reg      <= div_r;
                step_cnt_reg <= step_cnt_reg + STEP_CNT_W'(1);
            end
            if (cmd.digit_wr) begin
                count_reg    <= count_reg + COUNT_W'(1);
                rem_reg      <= '0;
                step_cnt_reg <= '0;
            end
            // count walks back down as digits are read out
            if (cmd.fetch) begin
                count_reg   <= count_dec;
                out_sel_reg <= OUT_DIGIT;
            end
            if (cmd.err_sel) begin
                out_sel_reg <= OUT_ERROR;
            end
            if (cmd.sign_sel) begin
                out_sel_reg <= OUT_SIGN;
            end
        end
    end

    itra_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_digit_store (
        .aclk  (aclk),
        .we    (cmd.digit_wr),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (rem_reg),
        .re    (cmd.fetch),
        .raddr (count_dec[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        status.radix_ok   = (s_radix >= RADIX_MIN) && (s_radix <= RADIX_MAX);
        status.step_last  = (step_cnt_reg == STEP_CNT_W'(DIV_STEPS - 1));
        status.quot_zero  = (quot_reg == '0);
        status.count_full = (count_reg == COUNT_W'(STORE_DEPTH - 1));
        status.too_long   = (({1'b0, count_reg} + (COUNT_W + 1)'(neg_reg))
                             > (COUNT_W + 1)'(MAX_CHARS));
        status.neg        = neg_reg;
        status.idx_zero   = (count_reg == '0);
    end

    always_comb begin
        unique case (out_sel_reg)
            OUT_ERROR: begin
                m_character = CHAR_NONE;
                m_last      = 1'b1;
                m_error     = 1'b1;
            end
            OUT_SIGN: begin
                m_character = CHAR_MINUS;
                m_last      = 1'b0;
                m_error     = 1'b0;
            end
            OUT_DIGIT: begin
                m_character = digit_char(ram_rdata);
                m_last      = (count_reg == '0);
                m_error     = 1'b0;
            end
            default: begin
                m_character = CHAR_NONE;
                m_last      = 1'b1;
                m_error     = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/itra_ctrl.sv
// controller state machine: sequences division, digit writes and character output
module itra_ctrl
    import itra_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  itra_status_t status,
    output itra_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.radix_ok ? ST_DIVIDE : ST_ERROR;
                end
            end
            ST_DIVIDE: begin
                if (status.step_last) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                state_next = (status.quot_zero || status.count_full) ? ST_CHECK : ST_DIVIDE;
            end
            ST_CHECK: begin
                priority if (status.too_long) begin
                    state_next = ST_ERROR;
                end else if (status.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_DOUT;
                end
            end
            ST_ERROR: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (m_ready) begin
                    state_next = ST_DOUT;
                end
            end
            ST_DOUT: begin
                if (m_ready && status.idx_zero) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load    = 1'b1;
                    cmd.err_sel = !status.radix_ok;
                end
            end
            ST_DIVIDE: begin
                cmd.step = 1'b1;
            end
            ST_DIGIT: begin
                cmd.digit_wr = 1'b1;
            end
            ST_CHECK: begin
                priority if (status.too_long) begin
                    cmd.err_sel = 1'b1;
                end else if (status.neg) begin
                    cmd.sign_sel = 1'b1;
                end else begin
                    cmd.fetch = 1'b1;
                end
            end
            ST_ERROR: begin
                m_valid = 1'b1;
            end
            ST_SIGN: begin
                m_valid   = 1'b1;
                cmd.fetch = m_ready;
            end
            ST_DOUT: begin
                // next digit is read at the same edge the current one is taken
                m_valid   = 1'b1;
                cmd.fetch = m_ready && !status.idx_zero;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/integer_to_radix_ascii_unit.sv
// top level of the radix integer-to-ascii converter
// Formats one 64-bit value per transaction in radix 2..36 and sends its ASCII
// characters most significant first, '-' leading when negative is set, with
// m_last on the final character; a bad radix or a text over MAX_CHARS gives one
// character 0 with m_last and m_error set. One item is handled at a time: s_ready
// is high only while idle. Each digit is one full division in the shared divider
// (8 quotient bits per cycle over the padded value, then a digit-store write);
// after the last digit the characters follow at one per cycle while m_ready is
// high. Base 2 with 64 digits is the slowest case. The digit store needs no
// clearing after reset.
module integer_to_radix_ascii_unit
    import itra_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [63:0]        s_value,
    input  logic [RADIX_W-1:0] s_radix,
    input  logic               s_negative,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAR_W-1:0]  m_character,
    output logic               m_last,
    output logic               m_error
);

    itra_cmd_t    cmd;
    itra_status_t status;

    itra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    itra_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_value     (s_value),
        .s_radix     (s_radix),
        .s_negative  (s_negative),
        .m_character (m_character),
        .m_last      (m_last),
        .m_error     (m_error)
    );

endmodule
